/* rtl/paf_pkg.sv */
// Shared types and constants of the page arena allocator.
`timescale 1ns / 1ps
`default_nettype none
package paf_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 40;
  localparam int STAT_W = 3;
  localparam int TOTAL_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W = 5;
  localparam int PAGES_W = 9;

  localparam logic [SHIFT_W-1:0] PG_SHIFT_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] PG_SHIFT_MAX = 5'd24;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_ALLOC_AT = 2'd1,
    OP_FREE     = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_OVER_FREE  = 3'd2,
    ST_NO_FIT     = 3'd3,
    ST_OUTSIDE    = 3'd4,
    ST_NOT_ALLOC  = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] res;
    logic              carry;
  } alu_rsp_t;

endpackage
`default_nettype wire

/* rtl/page_arena_first_fit_allocator_unit.sv */
// Top level of the page arena allocator: sequencer, page table and free list.
`timescale 1ns / 1ps
`default_nettype none
// Page-granular first-fit arena allocator. One word on the input channel is one
// operation (allocate first fit, allocate at an address, free, clear) and gives
// exactly one result word. The block takes one word at a time: in_ready is high
// only while the sequencer is idle, and a finished result waits in the output
// register while the next word is accepted. An allocation runs its checks, then
// a free-list scan that reads one entry at a time, splits, and a list removal
// that searches for the entry and then shifts the tail down; a free releases the
// block and then does up to two removals as it merges. Scans and removals are
// paced by the one read port of the free-order memory. After reset, after a write
// to base, pages or shift, and for a clear word, a sweep over all MAX_PAGES
// entries rewrites the page table; no word is accepted during it, configuration
// writes are (and restart it).
module page_arena_first_fit_allocator_unit import paf_pkg::*; #(
  parameter int MAX_PAGES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [SIZE_W-1:0]    in_request_size,
  input  wire logic [ADDR_W-1:0]    in_target_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic [ADDR_W-1:0]         out_block_address,
  output logic [SIZE_W-1:0]         out_granted_bytes,
  output logic [SIZE_W-1:0]         out_free_bytes_left,
  output logic                      out_arena_empty,
  output logic [TOTAL_W-1:0]        out_free_block_total
);

  localparam int PW = $clog2(MAX_PAGES);  // page index bits
  localparam int LW = PW + 1;             // page counts, lengths, none code
  localparam int XW = LW + 1;             // page sums
  localparam logic [LW-1:0] NONE_PG = LW'(MAX_PAGES);

  // One page-table entry: block length, lower neighbour head, head and used flags.
  typedef struct packed {
    logic [LW-1:0] len;
    logic [LW-1:0] low;
    logic          head;
    logic          alloc;
  } rec_t;
  localparam int RW = $bits(rec_t);

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_PRE, S_SZ, S_NEED, S_CK1, S_CK2,
    S_SC_RO, S_SC_OW, S_SC_CK, S_SEQ,
    S_SP_RD, S_SP_CK, S_SP_PW,
    S_TK_RD, S_TK_WR,
    S_RM_RO, S_RM_CK, S_SH_RD, S_SH_WR,
    S_LW_RD, S_LW_WR,
    S_FR_RD, S_FR_CK, S_FR_ADD, S_FR_UCK, S_FR_UM, S_FR_UZ,
    S_FR_LO, S_FR_LCK, S_FR_LM, S_FR_LZ,
    S_GR1, S_GR2, S_GR3, S_OUT
  } state_t;

  // ---------------------------------------------------------------- registers
  state_t state_r, state_nxt, ret_r, ret_nxt, sret_r, sret_nxt;
  logic [1:0]          ph_r, ph_nxt;
  opcode_t             op_r, op_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   baddr_r, baddr_nxt;
  logic [SIZE_W-1:0]   gr_r, gr_nxt;
  logic [ADDR_W-1:0]   diff_r, diff_nxt;
  logic                lt_r, lt_nxt;
  logic [LW-1:0]       need_r, need_nxt;
  logic [LW-1:0]       q_r, q_nxt;
  logic [LW-1:0]       i_r, i_nxt;
  logic [LW-1:0]       cand_r, cand_nxt;
  logic [LW-1:0]       found_r, found_nxt;
  logic [LW-1:0]       x_r, x_nxt;
  logic [LW-1:0]       lx_r, lx_nxt;
  logic [LW-1:0]       lv_r, lv_nxt;
  logic [LW-1:0]       sp_r, sp_nxt;
  logic [LW-1:0]       cut_r, cut_nxt;
  logic [LW-1:0]       u_r, u_nxt;
  rec_t                recp_r, recp_nxt, rec2_r, rec2_nxt, recs_r, recs_nxt;
  logic [LW-1:0]       flen_r, flen_nxt;
  logic [SIZE_W-1:0]   free_r, free_nxt;
  logic [LW-1:0]       used_r, used_nxt;
  logic [LW-1:0]       clr_i_r, clr_i_nxt;
  logic                clr_res_r, clr_res_nxt;
  logic [ADDR_W-1:0]   cfg_base_r;
  logic [PAGES_W-1:0]  cfg_pages_r;
  logic [SHIFT_W-1:0]  cfg_shift_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_baddr_r, out_baddr_nxt;
  logic [SIZE_W-1:0]   out_gr_r, out_gr_nxt;
  logic [SIZE_W-1:0]   out_free_r, out_free_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  // ------------------------------------------------------ effective settings
  logic [LW-1:0]      n_eff;
  logic [SHIFT_W-1:0] sh;
  logic [ADDR_W-1:0]  ps_m1;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  arena_bytes;
  logic [ADDR_W-1:0]  addr_al;

  always_comb begin
    if (cfg_pages_r == '0) begin
      n_eff = LW'(1);
    end else if (32'(cfg_pages_r) > 32'(MAX_PAGES)) begin
      n_eff = NONE_PG;
    end else begin
      n_eff = LW'(cfg_pages_r);
    end
    if (cfg_shift_r < PG_SHIFT_MIN) begin
      sh = PG_SHIFT_MIN;
    end else if (cfg_shift_r > PG_SHIFT_MAX) begin
      sh = PG_SHIFT_MAX;
    end else begin
      sh = cfg_shift_r;
    end
  end

  assign ps_m1       = (ADDR_W'(1) << sh) - ADDR_W'(1);
  assign base        = cfg_base_r & ~ps_m1;
  assign arena_bytes = ADDR_W'(n_eff) << sh;
  assign addr_al     = addr_r & ~ps_m1;

  // ------------------------------------------------------------- memories
  logic          pr_we;
  logic [PW-1:0] pr_wa, pr_ra;
  rec_t          pr_wd, pr_rd;
  logic [RW-1:0] pr_rd_bits;
  logic          ord_we;
  logic [PW-1:0] ord_wa, ord_ra, ord_wd, ord_rd;

  paf_ram #(.W(RW), .D(MAX_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_wa),
    .wdata (pr_wd),
    .raddr (pr_ra),
    .rdata (pr_rd_bits)
  );
  assign pr_rd = rec_t'(pr_rd_bits);

  paf_ram #(.W(PW), .D(MAX_PAGES)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_wa),
    .wdata (ord_wd),
    .raddr (ord_ra),
    .rdata (ord_rd)
  );

  // ------------------------------------------------------------ shared ALU
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  paf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ------------------------------------------------------------ sequencer
  logic [XW-1:0] sum_x, sum2_x;
  logic [LW-1:0] rl_l, i_inc;
  rec_t          rec_t0;
  logic          fit;

  assign i_inc    = i_r + LW'(1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;     sret_nxt = sret_r;
    ph_nxt = ph_r;         op_nxt = op_r;       size_nxt = size_r;
    addr_nxt = addr_r;     status_nxt = status_r;
    baddr_nxt = baddr_r;   gr_nxt = gr_r;       diff_nxt = diff_r;
    lt_nxt = lt_r;         need_nxt = need_r;   q_nxt = q_r;
    i_nxt = i_r;           cand_nxt = cand_r;   found_nxt = found_r;
    x_nxt = x_r;           lx_nxt = lx_r;       lv_nxt = lv_r;
    sp_nxt = sp_r;         cut_nxt = cut_r;     u_nxt = u_r;
    recp_nxt = recp_r;     rec2_nxt = rec2_r;   recs_nxt = recs_r;
    flen_nxt = flen_r;     free_nxt = free_r;   used_nxt = used_r;
    clr_i_nxt = clr_i_r;   clr_res_nxt = clr_res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r; out_baddr_nxt = out_baddr_r;
    out_gr_nxt = out_gr_r; out_free_nxt = out_free_r;
    out_empty_nxt = out_empty_r; out_total_nxt = out_total_r;
    pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    alu_req = '0;
    sum_x = '0; sum2_x = '0; rl_l = '0; rec_t0 = '0; fit = 1'b0;

    case (state_r)
      // Rewrite the page table: one block of the whole arena at page zero.
      S_CLR: begin
        pr_we = 1'b1;
        pr_wa = clr_i_r[PW-1:0];
        rec_t0.low = NONE_PG;
        if (clr_i_r == '0) begin
          rec_t0.len  = n_eff;
          rec_t0.head = 1'b1;
          ord_we = 1'b1;
        end
        pr_wd = rec_t0;
        if (clr_i_r == NONE_PG - LW'(1)) begin
          flen_nxt = LW'(1);
          free_nxt = SIZE_W'(n_eff) << sh;
          used_nxt = '0;
          state_nxt = clr_res_r ? S_OUT : S_IDLE;
        end else begin
          clr_i_nxt = clr_i_r + LW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = opcode_t'(in_opcode);
          size_nxt   = in_request_size;
          addr_nxt   = in_target_address;
          status_nxt = ST_OK;
          baddr_nxt  = '0;
          gr_nxt     = '0;
          state_nxt  = S_PRE;
        end
      end

      S_PRE: begin
        if (op_r == OP_CLEAR) begin
          clr_i_nxt = '0;
          clr_res_nxt = 1'b1;
          state_nxt = S_CLR;
        end else if (op_r == OP_FREE) begin
          state_nxt = S_CK1;
        end else if (size_r == '0) begin
          status_nxt = ST_ZERO_SIZE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SZ;
        end
      end

      S_SZ: begin
        alu_req.a = ADDR_W'(free_r);
        alu_req.b = ADDR_W'(size_r);
        alu_req.sub = 1'b1;
        if (alu_rsp.carry) begin
          status_nxt = ST_OVER_FREE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_NEED;
        end
      end

      // Round up to pages; an unaligned allocate-at costs one more page.
      S_NEED: begin
        alu_req.a = ADDR_W'(size_r);
        alu_req.b = ps_m1;
        need_nxt = LW'(alu_rsp.res >> sh);
        if (op_r == OP_ALLOC_AT) begin
          if ((addr_r & ps_m1) != '0) begin
            need_nxt = LW'(alu_rsp.res >> sh) + LW'(1);
          end
          state_nxt = S_CK1;
        end else begin
          i_nxt = '0;
          state_nxt = S_SC_RO;
        end
      end

      S_CK1: begin
        alu_req.a = addr_r;
        alu_req.b = base;
        alu_req.sub = 1'b1;
        diff_nxt = alu_rsp.res;
        lt_nxt = alu_rsp.carry;
        state_nxt = S_CK2;
      end

      S_CK2: begin
        alu_req.a = diff_r;
        alu_req.b = arena_bytes;
        alu_req.sub = 1'b1;
        q_nxt = LW'(diff_r >> sh);
        if (lt_r || !alu_rsp.carry) begin
          status_nxt = ST_OUTSIDE;
          state_nxt = S_OUT;
        end else if (op_r == OP_FREE) begin
          state_nxt = S_FR_RD;
        end else begin
          i_nxt = '0;
          state_nxt = S_SC_RO;
        end
      end

      // First-fit scan of the free list in insertion order.
      S_SC_RO: begin
        if (i_r >= flen_r || i_r >= NONE_PG) begin
          status_nxt = ST_NO_FIT;
          state_nxt = S_OUT;
        end else begin
          ord_ra = i_r[PW-1:0];
          state_nxt = S_SC_OW;
        end
      end

      S_SC_OW: begin
        cand_nxt = LW'(ord_rd);
        pr_ra = ord_rd;
        state_nxt = S_SC_CK;
      end

      S_SC_CK: begin
        if (op_r == OP_ALLOC) begin
          fit = (cand_r < n_eff) && (pr_rd.len >= need_r);
        end else begin
          sum_x  = XW'(q_r) + XW'(need_r);
          sum2_x = XW'(cand_r) + XW'(pr_rd.len);
          fit = (cand_r < n_eff) && (cand_r <= q_r) && (sum_x <= sum2_x);
        end
        if (fit) begin
          found_nxt = cand_r;
          ph_nxt = '0;
          state_nxt = S_SEQ;
        end else begin
          i_nxt = i_inc;
          state_nxt = S_SC_RO;
        end
      end

      // Carve the granted block: splits, then take it off the list.
      S_SEQ: begin
        if (op_r == OP_ALLOC) begin
          case (ph_r)
            2'd0: begin
              sp_nxt = found_r; cut_nxt = need_r; sret_nxt = S_SEQ;
              ph_nxt = 2'd1; state_nxt = S_SP_RD;
            end
            2'd1: begin
              x_nxt = found_r; ph_nxt = 2'd2; state_nxt = S_TK_RD;
            end
            default: state_nxt = S_GR1;
          endcase
        end else begin
          case (ph_r)
            2'd0: begin
              ph_nxt = 2'd1;
              if (q_r > found_r) begin
                sp_nxt = found_r; cut_nxt = q_r - found_r; sret_nxt = S_SEQ;
                state_nxt = S_SP_RD;
              end
            end
            2'd1: begin
              sp_nxt = q_r; cut_nxt = need_r; sret_nxt = S_SEQ;
              ph_nxt = 2'd2; state_nxt = S_SP_RD;
            end
            2'd2: begin
              x_nxt = q_r; ph_nxt = 2'd3; state_nxt = S_TK_RD;
            end
            default: state_nxt = S_GR1;
          endcase
        end
      end

      // Split: the remainder gets its own head and goes to the list back.
      S_SP_RD: begin
        pr_ra = sp_r[PW-1:0];
        state_nxt = S_SP_CK;
      end

      S_SP_CK: begin
        sum_x = XW'(sp_r) + XW'(cut_r);
        rl_l  = pr_rd.len - cut_r;
        sum2_x = sum_x + XW'(rl_l);
        if (cut_r == '0 || sp_r >= n_eff || pr_rd.len <= cut_r ||
            sum_x >= XW'(n_eff)) begin
          state_nxt = sret_r;
        end else begin
          pr_we = 1'b1;
          pr_wa = sum_x[PW-1:0];
          rec_t0.len  = rl_l;
          rec_t0.low  = sp_r;
          rec_t0.head = 1'b1;
          pr_wd = rec_t0;
          recs_nxt = pr_rd;
          recs_nxt.len = cut_r;
          lv_nxt = LW'(sum_x);
          lx_nxt = LW'(sum2_x);
          if (sum2_x < XW'(n_eff)) begin
            ret_nxt = S_SP_PW;
            state_nxt = S_LW_RD;
          end else begin
            state_nxt = S_SP_PW;
          end
        end
      end

      S_SP_PW: begin
        pr_we = 1'b1;
        pr_wa = sp_r[PW-1:0];
        pr_wd = recs_r;
        if (flen_r < NONE_PG) begin
          ord_we = 1'b1;
          ord_wa = flen_r[PW-1:0];
          ord_wd = lv_r[PW-1:0];
          flen_nxt = flen_r + LW'(1);
        end
        state_nxt = sret_r;
      end

      S_TK_RD: begin
        pr_ra = x_r[PW-1:0];
        state_nxt = S_TK_WR;
      end

      S_TK_WR: begin
        pr_we = 1'b1;
        pr_wa = x_r[PW-1:0];
        rec_t0 = pr_rd;
        rec_t0.alloc = 1'b1;
        pr_wd = rec_t0;
        used_nxt = used_r + LW'(1);
        i_nxt = '0;
        ret_nxt = S_SEQ;
        state_nxt = S_RM_RO;
      end

      // Remove x from the list: search, then shift the tail down one slot.
      S_RM_RO: begin
        if (i_r >= flen_r || i_r >= NONE_PG) begin
          state_nxt = ret_r;
        end else begin
          ord_ra = i_r[PW-1:0];
          state_nxt = S_RM_CK;
        end
      end

      S_RM_CK: begin
        if (LW'(ord_rd) == x_r) begin
          state_nxt = S_SH_RD;
        end else begin
          i_nxt = i_inc;
          state_nxt = S_RM_RO;
        end
      end

      S_SH_RD: begin
        if (i_inc < flen_r) begin
          ord_ra = i_inc[PW-1:0];
          state_nxt = S_SH_WR;
        end else begin
          flen_nxt = flen_r - LW'(1);
          state_nxt = ret_r;
        end
      end

      S_SH_WR: begin
        ord_we = 1'b1;
        ord_wa = i_r[PW-1:0];
        ord_wd = ord_rd;
        i_nxt = i_inc;
        state_nxt = S_SH_RD;
      end

      // Point the lower-neighbour field of page lx at lv.
      S_LW_RD: begin
        pr_ra = lx_r[PW-1:0];
        state_nxt = S_LW_WR;
      end

      S_LW_WR: begin
        pr_we = 1'b1;
        pr_wa = lx_r[PW-1:0];
        rec_t0 = pr_rd;
        rec_t0.low = lv_r;
        pr_wd = rec_t0;
        state_nxt = ret_r;
      end

      // Free: check the head, release it, then merge upward and downward.
      S_FR_RD: begin
        if (q_r >= n_eff) begin
          status_nxt = ST_NOT_ALLOC;
          state_nxt = S_OUT;
        end else begin
          pr_ra = q_r[PW-1:0];
          state_nxt = S_FR_CK;
        end
      end

      S_FR_CK: begin
        if (!pr_rd.head || !pr_rd.alloc) begin
          status_nxt = ST_NOT_ALLOC;
          state_nxt = S_OUT;
        end else begin
          baddr_nxt = addr_al;
          gr_nxt = SIZE_W'(pr_rd.len) << sh;
          rec_t0 = pr_rd;
          rec_t0.alloc = 1'b0;
          recp_nxt = rec_t0;
          pr_we = 1'b1;
          pr_wa = q_r[PW-1:0];
          pr_wd = rec_t0;
          if (used_r != '0) begin
            used_nxt = used_r - LW'(1);
          end
          if (flen_r < NONE_PG) begin
            ord_we = 1'b1;
            ord_wa = flen_r[PW-1:0];
            ord_wd = q_r[PW-1:0];
            flen_nxt = flen_r + LW'(1);
          end
          state_nxt = S_FR_ADD;
        end
      end

      S_FR_ADD: begin
        alu_req.a = ADDR_W'(free_r);
        alu_req.b = ADDR_W'(gr_r);
        free_nxt = alu_rsp.res[SIZE_W-1:0];
        sum_x = XW'(q_r) + XW'(recp_r.len);
        u_nxt = LW'(sum_x);
        if (sum_x < XW'(n_eff)) begin
          pr_ra = sum_x[PW-1:0];
          state_nxt = S_FR_UCK;
        end else begin
          state_nxt = S_FR_LO;
        end
      end

      S_FR_UCK: begin
        if (pr_rd.head && !pr_rd.alloc) begin
          rec2_nxt = pr_rd;
          x_nxt = u_r;
          i_nxt = '0;
          ret_nxt = S_FR_UM;
          state_nxt = S_RM_RO;
        end else begin
          state_nxt = S_FR_LO;
        end
      end

      S_FR_UM: begin
        rec_t0 = recp_r;
        rec_t0.len = recp_r.len + rec2_r.len;
        recp_nxt = rec_t0;
        pr_we = 1'b1;
        pr_wa = q_r[PW-1:0];
        pr_wd = rec_t0;
        state_nxt = S_FR_UZ;
      end

      S_FR_UZ: begin
        pr_we = 1'b1;
        pr_wa = u_r[PW-1:0];
        rec_t0.low = NONE_PG;
        rec_t0.alloc = rec2_r.alloc;
        pr_wd = rec_t0;
        sum_x = XW'(q_r) + XW'(recp_r.len);
        lx_nxt = LW'(sum_x);
        lv_nxt = q_r;
        if (sum_x < XW'(n_eff)) begin
          ret_nxt = S_FR_LO;
          state_nxt = S_LW_RD;
        end else begin
          state_nxt = S_FR_LO;
        end
      end

      S_FR_LO: begin
        if (recp_r.low < n_eff) begin
          pr_ra = recp_r.low[PW-1:0];
          state_nxt = S_FR_LCK;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_FR_LCK: begin
        if (pr_rd.head && !pr_rd.alloc) begin
          rec2_nxt = pr_rd;
          x_nxt = q_r;
          i_nxt = '0;
          ret_nxt = S_FR_LM;
          state_nxt = S_RM_RO;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_FR_LM: begin
        rec_t0 = rec2_r;
        rec_t0.len = rec2_r.len + recp_r.len;
        rec2_nxt = rec_t0;
        pr_we = 1'b1;
        pr_wa = recp_r.low[PW-1:0];
        pr_wd = rec_t0;
        state_nxt = S_FR_LZ;
      end

      S_FR_LZ: begin
        pr_we = 1'b1;
        pr_wa = q_r[PW-1:0];
        rec_t0.low = NONE_PG;
        rec_t0.alloc = recp_r.alloc;
        pr_wd = rec_t0;
        sum_x = XW'(recp_r.low) + XW'(rec2_r.len);
        lx_nxt = LW'(sum_x);
        lv_nxt = recp_r.low;
        if (sum_x < XW'(n_eff)) begin
          ret_nxt = S_OUT;
          state_nxt = S_LW_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end

      // Charge the granted pages against the free byte count.
      S_GR1: begin
        gr_nxt = SIZE_W'(need_r) << sh;
        state_nxt = S_GR2;
      end

      S_GR2: begin
        alu_req.a = ADDR_W'(free_r);
        alu_req.b = ADDR_W'(gr_r);
        alu_req.sub = 1'b1;
        free_nxt = alu_rsp.carry ? '0 : alu_rsp.res[SIZE_W-1:0];
        if (op_r == OP_ALLOC) begin
          state_nxt = S_GR3;
        end else begin
          baddr_nxt = addr_al;
          state_nxt = S_OUT;
        end
      end

      S_GR3: begin
        alu_req.a = base;
        alu_req.b = ADDR_W'(found_r) << sh;
        baddr_nxt = alu_rsp.res;
        state_nxt = S_OUT;
      end

      // Hold the result until the output register is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_baddr_nxt  = baddr_r;
          out_gr_nxt     = gr_r;
          out_free_nxt   = free_r;
          out_empty_nxt  = (used_r == '0);
          out_total_nxt  = TOTAL_W'(flen_r);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // A write to base, pages or shift restarts the clearing sweep with the new settings.
    if (cfg_we && (cfg_index == CFG_BASE || cfg_index == CFG_PAGES ||
                   cfg_index == CFG_SHIFT)) begin
      clr_i_nxt = '0;
      clr_res_nxt = 1'b0;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_i_r     <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
      ret_r       <= S_IDLE;
      sret_r      <= S_IDLE;
      flen_r      <= LW'(1);
      free_r      <= '0;
      used_r      <= '0;
      cfg_base_r  <= '0;
      cfg_pages_r <= PAGES_W'(256);
      cfg_shift_r <= SHIFT_W'(16);
    end else begin
      state_r     <= state_nxt;
      clr_i_r     <= clr_i_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      ret_r       <= ret_nxt;
      sret_r      <= sret_nxt;
      flen_r      <= flen_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      if (cfg_we && cfg_index == CFG_BASE) begin
        cfg_base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_PAGES) begin
        cfg_pages_r <= cfg_wdata[PAGES_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_SHIFT) begin
        cfg_shift_r <= cfg_wdata[SHIFT_W-1:0];
      end
    end
    op_r <= op_nxt;         size_r <= size_nxt;     addr_r <= addr_nxt;
    status_r <= status_nxt; baddr_r <= baddr_nxt;   gr_r <= gr_nxt;
    diff_r <= diff_nxt;     lt_r <= lt_nxt;         need_r <= need_nxt;
    q_r <= q_nxt;           i_r <= i_nxt;           cand_r <= cand_nxt;
    found_r <= found_nxt;   x_r <= x_nxt;           lx_r <= lx_nxt;
    lv_r <= lv_nxt;         sp_r <= sp_nxt;         cut_r <= cut_nxt;
    u_r <= u_nxt;           recp_r <= recp_nxt;     rec2_r <= rec2_nxt;
    recs_r <= recs_nxt;
    out_status_r <= out_status_nxt; out_baddr_r <= out_baddr_nxt;
    out_gr_r <= out_gr_nxt;         out_free_r <= out_free_nxt;
    out_empty_r <= out_empty_nxt;   out_total_r <= out_total_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_block_address    = out_baddr_r;
  assign out_granted_bytes    = out_gr_r;
  assign out_free_bytes_left  = out_free_r;
  assign out_arena_empty      = out_empty_r;
  assign out_free_block_total = out_total_r;

  // ------------------------------------------------------------ assertions
  a_flen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flen_r <= NONE_PG) else $error("free list longer than page count");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (used_r <= n_eff))
    else $error("more used blocks than pages");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_i_r == NONE_PG - LW'(1)) |=>
    (flen_r == LW'(1) && used_r == '0))
    else $error("clear sweep left stale list state");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_we) |=> (state_r == S_PRE))
    else $error("accepted word not started");

endmodule
`default_nettype wire

/* rtl/paf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module paf_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/paf_alu.sv */
// Shared 48-bit add/subtract unit; carry out is the borrow on subtract.
`timescale 1ns / 1ps
`default_nettype none
module paf_alu import paf_pkg::*; (
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [ADDR_W:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res   = sum[ADDR_W-1:0];
    rsp.carry = sum[ADDR_W];
  end

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the page arena first-fit allocator unit.
`timescale 1ns / 1ps
module testbench;
  import paf_pkg::*;

  localparam int ARENA_SLOTS = 256;     // page table depth, matches the DUT default
  localparam int WORDS_PER_PHASE = 250;
  localparam int LONG_HOLD = 3000;      // cycles of receiver back-pressure

  typedef struct {
    opcode_t           op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } arena_word_t;

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  granted;
    logic [SIZE_W-1:0]  free_left;
    logic               empty;
    logic [TOTAL_W-1:0] total;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = OP_CLEAR;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [ADDR_W-1:0] in_target_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic [SIZE_W-1:0] out_granted_bytes;
  logic [SIZE_W-1:0] out_free_bytes_left;
  logic out_arena_empty;
  logic [TOTAL_W-1:0] out_free_block_total;

  page_arena_first_fit_allocator_unit #(.MAX_PAGES(ARENA_SLOTS)) DUT (.*);

  always #1 clk = ~clk;

  // Shadow configuration and page table of the allocator.
  logic [ADDR_W-1:0]  shadow_base;
  logic [PAGES_W-1:0] shadow_pages;
  logic [SHIFT_W-1:0] shadow_shift;
  int unsigned blen [ARENA_SLOTS];
  int unsigned lower [ARENA_SLOTS];
  int unsigned forder [ARENA_SLOTS];
  bit          is_alloc [ARENA_SLOTS];
  bit          is_head [ARENA_SLOTS];
  int unsigned flen;
  int unsigned used_blocks;
  logic [63:0] free_bytes;

  arena_word_t       pending_words[$];
  alloc_result_t     expected_results[$];
  logic [ADDR_W-1:0] live_blocks[$];    // heads handed out and not yet freed
  int                mismatch_count = 0;
  bit                hold_request = 1'b0;

  function automatic int unsigned eff_pages();
    int unsigned n;
    n = shadow_pages;
    if (n == 0) n = 1;
    if (n > ARENA_SLOTS) n = ARENA_SLOTS;
    return n;
  endfunction

  function automatic int unsigned eff_shift();
    int unsigned s;
    s = shadow_shift;
    if (s < PG_SHIFT_MIN) s = PG_SHIFT_MIN;
    if (s > PG_SHIFT_MAX) s = PG_SHIFT_MAX;
    return s;
  endfunction

  function automatic logic [63:0] eff_base();
    return {16'd0, shadow_base} & ~((64'd1 << eff_shift()) - 64'd1);
  endfunction

  // Reset the page table to one free block spanning the arena.
  function automatic void arena_clear();
    for (int i = 0; i < ARENA_SLOTS; i++) begin
      blen[i] = 0;
      is_alloc[i] = 1'b0;
      is_head[i] = 1'b0;
      forder[i] = 0;
      lower[i] = ARENA_SLOTS;
    end
    blen[0] = eff_pages();
    is_head[0] = 1'b1;
    flen = 1;
    free_bytes = 64'(eff_pages()) << eff_shift();
    used_blocks = 0;
    live_blocks.delete();
  endfunction

  function automatic void list_push(int unsigned p);
    if (flen < ARENA_SLOTS) begin
      forder[flen] = p;
      flen++;
    end
  endfunction

  function automatic void list_remove(int unsigned p);
    for (int i = 0; i < flen; i++) begin
      if (forder[i] == p) begin
        for (int j = i; j + 1 < flen; j++) forder[j] = forder[j + 1];
        flen--;
        return;
      end
    end
  endfunction

  // Cut a free block after cut pages; the tail goes to the back of the list.
  function automatic void split_block(int unsigned parent, int unsigned cut);
    int unsigned n, r, u;
    n = eff_pages();
    if (cut == 0 || parent >= n || blen[parent] <= cut) return;
    r = parent + cut;
    if (r >= n) return;
    blen[r] = blen[parent] - cut;
    lower[r] = parent;
    is_head[r] = 1'b1;
    is_alloc[r] = 1'b0;
    u = r + blen[r];
    if (u < n) lower[u] = r;
    blen[parent] = cut;
    list_push(r);
  endfunction

  function automatic void take_block(int unsigned p);
    is_alloc[p] = 1'b1;
    used_blocks++;
    list_remove(p);
  endfunction

  function automatic alloc_result_t predict_word(arena_word_t w);
    int unsigned n, sh, found, p, q, u, l, uu;
    logic [63:0] ps, base, arena_bytes, need, a, granted, baddr, addr, size;
    alloc_result_t r;
    n = eff_pages();
    sh = eff_shift();
    ps = 64'd1 << sh;
    base = eff_base();
    arena_bytes = 64'(n) << sh;
    addr = {16'd0, w.addr};
    size = {24'd0, w.size};
    r.status = ST_OK;
    baddr = '0;
    granted = '0;
    found = ARENA_SLOTS;
    a = addr & ~(ps - 64'd1);
    if (w.op == OP_CLEAR) begin
      arena_clear();
    end else if (w.op == OP_FREE) begin
      if (addr < base || addr - base >= arena_bytes) begin
        r.status = ST_OUTSIDE;
      end else begin
        p = int'((a - base) >> sh);
        if (!is_head[p] || !is_alloc[p]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          granted = 64'(blen[p]) << sh;
          baddr = a;
          free_bytes += granted;
          foreach (live_blocks[k]) if (live_blocks[k] == a[ADDR_W-1:0]) begin
            live_blocks.delete(k);
            break;
          end
          // Release, then merge with a free upper and a free lower neighbor.
          is_alloc[p] = 1'b0;
          if (used_blocks > 0) used_blocks--;
          list_push(p);
          u = p + blen[p];
          if (u < n && is_head[u] && !is_alloc[u]) begin
            list_remove(u);
            blen[p] += blen[u];
            is_head[u] = 1'b0;
            blen[u] = 0;
            lower[u] = ARENA_SLOTS;
            uu = p + blen[p];
            if (uu < n) lower[uu] = p;
          end
          l = lower[p];
          if (l < n && is_head[l] && !is_alloc[l]) begin
            list_remove(p);
            blen[l] += blen[p];
            is_head[p] = 1'b0;
            blen[p] = 0;
            lower[p] = ARENA_SLOTS;
            uu = l + blen[l];
            if (uu < n) lower[uu] = l;
          end
        end
      end
    end else if (size == 0) begin
      r.status = ST_ZERO_SIZE;
    end else if (size > free_bytes) begin
      r.status = ST_OVER_FREE;
    end else begin
      need = (size + ps - 64'd1) >> sh;
      if (w.op == OP_ALLOC) begin
        for (int i = 0; i < flen; i++) begin
          p = forder[i];
          if (p < n && 64'(blen[p]) >= need) begin
            found = p;
            break;
          end
        end
        if (found == ARENA_SLOTS) begin
          r.status = ST_NO_FIT;
        end else begin
          split_block(found, int'(need));
          take_block(found);
          baddr = base + (64'(found) << sh);
        end
      end else begin
        if (a != addr) need += 64'd1;
        if (addr < base || addr - base >= arena_bytes) begin
          r.status = ST_OUTSIDE;
        end else begin
          q = int'((a - base) >> sh);
          for (int i = 0; i < flen; i++) begin
            p = forder[i];
            if (p < n && p <= q && 64'(q) + need <= 64'(p) + 64'(blen[p])) begin
              found = p;
              break;
            end
          end
          if (found == ARENA_SLOTS) begin
            r.status = ST_NO_FIT;
          end else begin
            if (q > found) split_block(found, q - found);
            split_block(q, int'(need));
            take_block(q);
            baddr = a;
          end
        end
      end
      if (r.status == ST_OK) begin
        granted = need << sh;
        free_bytes = (granted <= free_bytes) ? free_bytes - granted : 64'd0;
        live_blocks.push_back(baddr[ADDR_W-1:0]);
      end
    end
    r.addr = baddr[ADDR_W-1:0];
    r.granted = granted[SIZE_W-1:0];
    r.free_left = free_bytes[SIZE_W-1:0];
    r.empty = (used_blocks == 0);
    r.total = flen[TOTAL_W-1:0];
    return r;
  endfunction

  // Driver: bursts of words separated by random gaps; hold a word until taken.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    arena_word_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        w.op = opcode_t'(in_opcode);
        w.size = in_request_size;
        w.addr = in_target_address;
        expected_results.push_back(predict_word(w));
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_opcode <= w.op;
          in_request_size <= w.size;
          in_target_address <= w.addr;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: duty-cycle stall pattern, re-picked on every wrap; one long hold on request.
  int ready_period = 1;
  int ready_duty = 1;
  int ready_phase = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (ready_phase >= ready_period) begin
        ready_phase = 0;
        ready_period = $urandom_range(1, 16);
        ready_duty = ($urandom_range(0, 3) == 0) ? ready_period
                                                  : $urandom_range(0, ready_period);
      end
      out_ready <= (ready_phase < ready_duty);
      ready_phase++;
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending");
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          mismatch_count++;
        end
        if (out_block_address !== e.addr) begin
          $error("block_address: expected %h actual %h", e.addr, out_block_address);
          mismatch_count++;
        end
        if (out_granted_bytes !== e.granted) begin
          $error("granted_bytes: expected %h actual %h", e.granted, out_granted_bytes);
          mismatch_count++;
        end
        if (out_free_bytes_left !== e.free_left) begin
          $error("free_bytes_left: expected %h actual %h", e.free_left, out_free_bytes_left);
          mismatch_count++;
        end
        if (out_arena_empty !== e.empty) begin
          $error("arena_empty: expected %0d actual %0d", e.empty, out_arena_empty);
          mismatch_count++;
        end
        if (out_free_block_total !== e.total) begin
          $error("free_block_total: expected %0d actual %0d", e.total, out_free_block_total);
          mismatch_count++;
        end
      end
    end
  end

  task automatic queue_word(opcode_t op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    arena_word_t w;
    w.op = op;
    w.size = size;
    w.addr = addr;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BASE:  shadow_base = data;
      CFG_PAGES: shadow_pages = data[PAGES_W-1:0];
      default:   shadow_shift = data[SHIFT_W-1:0];
    endcase
    arena_clear();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: frees aim at live blocks, allocate-at inside the arena.
  task automatic queue_random_word();
    logic [63:0] ps, base, rnd, size, addr;
    int unsigned n, pick;
    opcode_t op;
    ps = 64'd1 << eff_shift();
    base = eff_base();
    n = eff_pages();
    rnd = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    op = (pick < 38) ? OP_ALLOC : (pick < 55) ? OP_ALLOC_AT : (pick < 98) ? OP_FREE : OP_CLEAR;
    case ($urandom_range(0, 15))
      0:       size = 0;
      1:       size = rnd;
      2:       size = ps * $urandom_range(1, n);
      default: size = $urandom_range(1, 4 * int'(ps));
    endcase
    pick = $urandom_range(0, 9);
    if (op == OP_FREE && live_blocks.size() > 0 && pick < 8) begin
      addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      if ($urandom_range(0, 3) == 0) addr += $urandom_range(0, int'(ps) - 1);
    end else if (pick < 7) begin
      addr = base + ps * $urandom_range(0, n - 1);
      if ($urandom_range(0, 2) == 0) addr += $urandom_range(0, int'(ps) - 1);
    end else if (pick == 7) begin
      addr = base - 64'd1;
    end else if (pick == 8) begin
      addr = base + (64'(n) * ps);
    end else begin
      addr = {$urandom, $urandom};
    end
    queue_word(op, size[SIZE_W-1:0], addr[ADDR_W-1:0]);
  endtask

  initial begin
    logic [ADDR_W-1:0] phase_base [7];
    logic [ADDR_W-1:0] phase_pages [7];
    logic [ADDR_W-1:0] phase_shift [7];
    shadow_base = '0;
    shadow_pages = 9'd256;
    shadow_shift = 5'd16;
    arena_clear();
    phase_base = '{48'd0, {$urandom, 16'd0}, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_1FFF,
                   48'd0, {$urandom, $urandom_range(0, 65535)}, 48'h1234_5678_9ABC};
    phase_pages = '{256, 1, 256, 0, 511, $urandom_range(2, 40), 7};
    phase_shift = '{16, 12, 24, 0, 31, $urandom_range(13, 20), 12};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening on the reset arena: 256 pages of 64 KiB at address zero.
    queue_word(OP_ALLOC, 40'd0, 48'd0);                   // zero size
    queue_word(OP_ALLOC_AT, 40'd0, 48'h20000);            // zero size, allocate-at
    queue_word(OP_ALLOC, 40'hFF_FFFF_FFFF, 48'd0);        // more than is free
    queue_word(OP_ALLOC, 40'd1, 48'd0);
    queue_word(OP_ALLOC, 40'h10001, 48'd0);               // rounds up to two pages
    queue_word(OP_ALLOC_AT, 40'h10000, 48'h50123);        // unaligned: one extra page
    queue_word(OP_ALLOC_AT, 40'd1, 48'h10000);            // already taken: no fit
    queue_word(OP_ALLOC_AT, 40'd1, 48'h100_0000);         // just past the arena
    queue_word(OP_ALLOC_AT, 40'd1, 48'hFFFF_FFFF_FFFF);
    queue_word(OP_FREE, 40'd0, 48'h100_0000);             // free outside the arena
    queue_word(OP_FREE, 40'd0, 48'h30000);                // free page is not allocated
    queue_word(OP_FREE, 40'd0, 48'h20000);                // not a block head
    queue_word(OP_FREE, 40'hFF_FFFF_FFFF, 48'h1FFFF);     // unaligned free of page one
    queue_word(OP_FREE, 40'd0, 48'd0);                    // merges upward
    queue_word(OP_FREE, 40'd0, 48'h50000);
    queue_word(OP_ALLOC, 40'h100_0000, 48'd0);            // the whole arena
    queue_word(OP_ALLOC, 40'd1, 48'd0);                   // nothing left
    queue_word(OP_FREE, 40'd0, 48'd0);
    queue_word(OP_ALLOC_AT, 40'h100_0000, 48'd0);         // whole arena at its base
    queue_word(OP_ALLOC, 40'd1, 48'd0);
    queue_word(OP_CLEAR, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_word(OP_ALLOC, 40'hFF_FFFF, 48'd0);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_write(CFG_BASE, phase_base[ph]);
        cfg_write(CFG_PAGES, phase_pages[ph]);
        cfg_write(CFG_SHIFT, phase_shift[ph]);
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // Keep the backlog short so frees can target blocks granted so far.
        while (pending_words.size() > 16) @(posedge clk);
        if (ph == 0 && k == 60) hold_request = 1'b1;
        if (ph == 0 && k == 140) wait_drained();
        queue_random_word();
      end
    end

    wait_drained();
    repeat (ARENA_SLOTS + 40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("PASS page_arena_first_fit_allocator_unit");
    else
      $display("FAIL page_arena_first_fit_allocator_unit");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL page_arena_first_fit_allocator_unit");
    $finish;
  end

endmodule
